// ===== sv/smx_pkg.sv =====
// Shared types, constants and helper functions of the spin speed mixer.
package smx_pkg;

  // Action codes carried on the input side
  localparam logic [1:0] ACT_APPLY   = 2'd0;
  localparam logic [1:0] ACT_PREVIEW = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  localparam int NUM_WHEELS = 3;
  localparam int SPEED_W    = 9;
  localparam int POWER_W    = 8;
  localparam int ANGLE_W    = 10;
  localparam int INTEN_W    = 10;
  localparam int K_W        = 17;   // 32768 - cos, 0..65536
  localparam int PROD_W     = 40;   // shared multiplier result
  localparam int MAG_W      = 19;   // |2*num + den| >> 17

  // 255 * 65536: the full-scale numerator term
  localparam logic signed [28:0] DEN_EXACT   = 29'sd16711680;
  localparam logic [MAG_W-1:0]   CLAMP_LIMIT = 19'd65025;  // 255 * 255

  // round(32768 * cos(d deg)), d = 0..90
  localparam logic [15:0] COS_Q15 [0:90] = '{
    16'd32768, 16'd32763, 16'd32748, 16'd32723, 16'd32688, 16'd32643, 16'd32588,
    16'd32524, 16'd32449, 16'd32365, 16'd32270, 16'd32166, 16'd32052, 16'd31928,
    16'd31795, 16'd31651, 16'd31499, 16'd31336, 16'd31164, 16'd30983, 16'd30792,
    16'd30592, 16'd30382, 16'd30163, 16'd29935, 16'd29698, 16'd29452, 16'd29197,
    16'd28932, 16'd28660, 16'd28378, 16'd28088, 16'd27789, 16'd27482, 16'd27166,
    16'd26842, 16'd26510, 16'd26170, 16'd25822, 16'd25466, 16'd25102, 16'd24730,
    16'd24351, 16'd23965, 16'd23571, 16'd23170, 16'd22763, 16'd22348, 16'd21926,
    16'd21498, 16'd21063, 16'd20622, 16'd20174, 16'd19720, 16'd19261, 16'd18795,
    16'd18324, 16'd17847, 16'd17364, 16'd16877, 16'd16384, 16'd15886, 16'd15384,
    16'd14876, 16'd14365, 16'd13848, 16'd13328, 16'd12803, 16'd12275, 16'd11743,
    16'd11207, 16'd10668, 16'd10126, 16'd9580,  16'd9032,  16'd8481,  16'd7927,
    16'd7371,  16'd6813,  16'd6252,  16'd5690,  16'd5126,  16'd4560,  16'd3993,
    16'd3425,  16'd2856,  16'd2286,  16'd1715,  16'd1144,  16'd572,   16'd0
  };

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;       // capture the accepted beat
    logic       cos;        // look up 1 - alignment for cos_wheel
    logic       mul1;       // intensity * k
    logic       mul2;       // power * (den - intensity * k)
    logic       fin;        // round offset, sign and magnitude
    logic       div;        // divide by 255, clamp, store wheel speed
    logic       store;      // update cache and output register
    logic [1:0] wheel;
    logic [1:0] cos_wheel;
  } smx_cmd_t;

  function automatic logic [9:0] wheel_deg(input logic [1:0] w);
    logic [9:0] d;
    case (w)
      2'd1:    d = 10'd120;
      2'd2:    d = 10'd240;
      default: d = 10'd0;
    endcase
    return d;
  endfunction

  // 32768 - cos(wheel - angle) in Q15, angle already reduced to 0..359
  function automatic logic [K_W-1:0] spin_k(input logic [8:0] ang, input logic [1:0] w);
    logic [9:0]  d;
    logic [6:0]  idx;
    logic        neg;
    logic [15:0] m;
    d = wheel_deg(w) + 10'd360 - {1'b0, ang};
    if (d >= 10'd360) d = d - 10'd360;
    if (d <= 10'd90) begin
      idx = d[6:0];
      neg = 1'b0;
    end else if (d <= 10'd180) begin
      idx = 7'(10'd180 - d);
      neg = 1'b1;
    end else if (d <= 10'd270) begin
      idx = 7'(d - 10'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(10'd360 - d);
      neg = 1'b0;
    end
    m = COS_Q15[idx];
    return neg ? (17'd32768 + {1'b0, m}) : (17'd32768 - {1'b0, m});
  endfunction

endpackage

// ===== sv/three_wheel_spin_speed_mixer.sv =====
// Top level of the three-wheel spin speed mixer.
//
// Usage:
//   Input beats carry a power, a spin angle in degrees (-1 for none) and a
//   spin intensity (255 = full spin, above 255 drives wheels in reverse);
//   in_tuser selects apply (update the speed cache), preview or clear cache.
//   Every input beat yields exactly one output beat with three signed wheel
//   speeds (wheels at 0, 120 and 240 degrees) and three write flags that
//   mark wheels whose drive changed since the last apply.
// Sequence:
//   One beat is worked at a time. The three wheels go one after another
//   through a single shared multiplier in the MUL1, MUL2, FIN and DIV steps
//   each, after a lookup step (S_COS) for the first wheel (later lookups
//   overlap DIV); the next beat is accepted once the result is stored.
// Reset and stall:
//   Reset empties the output register and invalidates the speed cache.
//   A finished result holds in the output register while out_tready is low;
//   the next beat is accepted and worked meanwhile and then waits until the
//   register drains.
module three_wheel_spin_speed_mixer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // power[7:0], spin_angle[17:8], spin_intensity[27:18]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // wheel_speed_a[8:0], wheel_speed_b[17:9],
                                  // wheel_speed_c[26:18], write_a[27], write_b[28],
                                  // write_c[29]
);
  import smx_pkg::*;

  smx_cmd_t                  cmd;
  logic signed [SPEED_W-1:0] wheel_speed [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]     write_flag;

  // sequence the per-wheel steps and own the output handshake
  smx_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // arithmetic, speed cache and result register
  smx_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .action         (in_tuser),
    .power          (in_tdata[7:0]),
    .spin_angle     ($signed(in_tdata[17:8])),
    .spin_intensity (in_tdata[27:18]),
    .wheel_speed    (wheel_speed),
    .write_flag     (write_flag)
  );

  // pack the result beat, lowest field first
  assign out_tdata = {2'b0, write_flag, wheel_speed[2], wheel_speed[1], wheel_speed[0]};

endmodule

// ===== sv/smx_ctrl.sv =====
// Sequencing state machine of the spin speed mixer.
module smx_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output smx_pkg::smx_cmd_t cmd
);
  import smx_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_COS, S_MUL1, S_MUL2, S_FIN, S_DIV, S_HOLD
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] wheel_r, wheel_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    wheel_nxt     = wheel_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.wheel     = wheel_r;
    cmd.cos_wheel = wheel_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          wheel_nxt = 2'd0;
          state_nxt = S_COS;
        end
      end
      S_COS: begin
        cmd.cos   = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (wheel_r == 2'(NUM_WHEELS - 1)) begin
          state_nxt = S_HOLD;
        end else begin
          // overlap the next wheel's table lookup with this division
          cmd.cos       = 1'b1;
          cmd.cos_wheel = wheel_r + 2'd1;
          wheel_nxt     = wheel_r + 2'd1;
          state_nxt     = S_MUL1;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.store     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wheel_r     <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wheel_r     <= wheel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/smx_dp.sv =====
// Datapath of the spin speed mixer: shared multiplier, rounding, cache, result register.
module smx_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  smx_pkg::smx_cmd_t                    cmd,
  input  logic [1:0]                           action,
  input  logic [smx_pkg::POWER_W-1:0]          power,
  input  logic signed [smx_pkg::ANGLE_W-1:0]   spin_angle,
  input  logic [smx_pkg::INTEN_W-1:0]          spin_intensity,
  output logic signed [smx_pkg::SPEED_W-1:0]   wheel_speed [smx_pkg::NUM_WHEELS],
  output logic [smx_pkg::NUM_WHEELS-1:0]       write_flag
);
  import smx_pkg::*;

  logic [1:0]                action_r;
  logic [POWER_W-1:0]        power_r;
  logic [INTEN_W-1:0]        inten_r;
  logic [8:0]                ang_r;
  logic                      bypass_r;
  logic [K_W-1:0]            k_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [MAG_W-1:0]          mag_r;
  logic                      sign_r;
  logic signed [SPEED_W-1:0] sp_r    [NUM_WHEELS];
  logic signed [SPEED_W-1:0] cache_r [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]     valid_r;
  logic signed [SPEED_W-1:0] out_sp_r [NUM_WHEELS];
  logic [NUM_WHEELS-1:0]     out_wr_r;

  logic [8:0]                ang_in;
  logic signed [28:0]        op_a;
  logic signed [10:0]        op_b;
  logic signed [PROD_W-1:0]  mul_res;
  logic signed [37:0]        rnd_x;
  logic [37:0]               rnd_abs;
  logic [16:0]               div_sum;
  logic [7:0]                quo;
  logic signed [SPEED_W-1:0] div_sp;
  logic signed [SPEED_W-1:0] new_sp [NUM_WHEELS];

  // reduce the angle to one turn
  assign ang_in = (spin_angle[8:0] >= 9'd360) ? (spin_angle[8:0] - 9'd360) : spin_angle[8:0];

  // one multiplier serves both products of a wheel
  always_comb begin
    if (cmd.mul1) begin
      op_a = $signed({12'b0, k_r});
      op_b = $signed({1'b0, inten_r});
    end else begin
      op_a = DEN_EXACT - prod_r[28:0];
      op_b = $signed({3'b0, power_r});
    end
  end
  assign mul_res = PROD_W'(op_a) * PROD_W'(op_b);

  // 2*num + den, then sign and magnitude for truncation toward zero
  assign rnd_x   = {prod_r[36:0], 1'b0} + 38'(DEN_EXACT);
  assign rnd_abs = rnd_x[37] ? 38'(-rnd_x) : 38'(rnd_x);

  // divide by 255, exact for quotients below 255
  assign div_sum = {1'b0, mag_r[15:0]} + {9'b0, mag_r[15:8]} + 17'd1;
  assign quo     = (mag_r >= CLAMP_LIMIT) ? 8'd255 : div_sum[15:8];
  assign div_sp  = sign_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      new_sp[i] = bypass_r ? $signed({1'b0, power_r}) : sp_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= action;
      power_r  <= power;
      inten_r  <= spin_intensity;
      ang_r    <= ang_in;
      bypass_r <= spin_angle[9] || (spin_intensity == '0);
    end
    if (cmd.cos) k_r <= spin_k(ang_r, cmd.cos_wheel);
    if (cmd.mul1 || cmd.mul2) prod_r <= mul_res;
    if (cmd.fin) begin
      mag_r  <= rnd_abs[35:17];
      sign_r <= rnd_x[37];
    end
    if (cmd.div) sp_r[cmd.wheel] <= div_sp;
    if (cmd.store) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        if (action_r == ACT_CLEAR) begin
          out_sp_r[i] <= '0;
          out_wr_r[i] <= 1'b0;
        end else begin
          out_sp_r[i] <= new_sp[i];
          out_wr_r[i] <= (action_r == ACT_APPLY) &&
                         (!valid_r[i] || (cache_r[i] != new_sp[i]));
          if (action_r == ACT_APPLY) cache_r[i] <= new_sp[i];
        end
      end
    end
  end

  // cache valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.store) begin
      if (action_r == ACT_CLEAR) valid_r <= '0;
      else if (action_r == ACT_APPLY) valid_r <= '1;
    end
  end

  assign wheel_speed = out_sp_r;
  assign write_flag  = out_wr_r;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the three-wheel spin speed mixer.
`timescale 1ns / 100ps

import smx_pkg::*;

// Tracks the wheel speed cache, predicts each result beat and checks it.
class wheel_mix_board;
  int                cos_q15 [91];
  logic signed [8:0] speed_cache [3];
  bit                cache_ok [3];
  logic [29:0]       expected_mix [$];
  int                errors;

  function new();
    cos_q15 = '{
      32768, 32763, 32748, 32723, 32688, 32643, 32588, 32524, 32449, 32365,
      32270, 32166, 32052, 31928, 31795, 31651, 31499, 31336, 31164, 30983,
      30792, 30592, 30382, 30163, 29935, 29698, 29452, 29197, 28932, 28660,
      28378, 28088, 27789, 27482, 27166, 26842, 26510, 26170, 25822, 25466,
      25102, 24730, 24351, 23965, 23571, 23170, 22763, 22348, 21926, 21498,
      21063, 20622, 20174, 19720, 19261, 18795, 18324, 17847, 17364, 16877,
      16384, 15886, 15384, 14876, 14365, 13848, 13328, 12803, 12275, 11743,
      11207, 10668, 10126,  9580,  9032,  8481,  7927,  7371,  6813,  6252,
       5690,  5126,  4560,  3993,  3425,  2856,  2286,  1715,  1144,   572,
          0
    };
    errors = 0;
    foreach (cache_ok[w]) cache_ok[w] = 1'b0;
  endfunction

  // Q15 cosine of a whole number of degrees, folded onto the first quadrant.
  function int cos_of(int deg);
    int d;
    d = deg % 360;
    if (d <= 90) return cos_q15[d];
    if (d <= 180) return -cos_q15[180 - d];
    if (d <= 270) return -cos_q15[d - 180];
    return cos_q15[360 - d];
  endfunction

  // Exact speed of one wheel: power * (1 - I/255 * (1 - a)), rounded, clamped.
  function logic signed [8:0] wheel_drive(longint power, longint inten, int wheel, int ang);
    longint full;
    longint c;
    longint num;
    longint r;
    full = 64'sd255 * 64'sd65536;
    c    = cos_of(wheel + 360 - ang);
    num  = power * (full - inten * (64'sd32768 - c));
    r    = (2 * num + full) / (2 * full);
    if (r > 255) r = 255;
    if (r < -255) r = -255;
    return 9'(r);
  endfunction

  function void note_beat(logic [1:0] act, logic [7:0] pw, logic [9:0] ang,
                          logic [9:0] inten);
    logic signed [8:0] spd [3];
    logic [2:0]        wr;
    int                a;
    wr = 3'b000;
    if (act == ACT_CLEAR) begin
      foreach (cache_ok[w]) cache_ok[w] = 1'b0;
      expected_mix.push_back('0);
      return;
    end
    if (ang[9] || inten == 10'd0) begin
      foreach (spd[w]) spd[w] = $signed({1'b0, pw});
    end else begin
      a = int'(ang) % 360;
      foreach (spd[w]) spd[w] = wheel_drive(pw, inten, 120 * w, a);
    end
    if (act == ACT_APPLY) begin
      foreach (spd[w]) begin
        if (!cache_ok[w] || speed_cache[w] != spd[w]) begin
          wr[w]          = 1'b1;
          speed_cache[w] = spd[w];
          cache_ok[w]    = 1'b1;
        end
      end
    end
    expected_mix.push_back({wr, spd[2], spd[1], spd[0]});
  endfunction

  task report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task check_beat(logic [31:0] word);
    logic [29:0] want;
    string       tag;
    if (expected_mix.size() == 0) begin
      report_mismatch("unexpected result beat", int'(word), 0);
      return;
    end
    want = expected_mix.pop_front();
    for (int w = 0; w < 3; w++) begin
      tag = $sformatf("wheel_speed %0d", w);
      if (word[9*w +: 9] !== want[9*w +: 9])
        report_mismatch(tag, int'($signed(word[9*w +: 9])), int'($signed(want[9*w +: 9])));
      tag = $sformatf("write flag %0d", w);
      if (word[27+w] !== want[27+w])
        report_mismatch(tag, int'(word[27+w]), int'(want[27+w]));
    end
  endtask

  function int pending();
    return expected_mix.size();
  endfunction
endclass

module tb_top;

  // Unused action code; the block treats it as preview.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam logic [9:0] NO_SPIN   = 10'h3FF;   // -1
  // Longest correct quiet spell is a sender gap, one full beat of work and a
  // receiver stall; allow many times that.
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1350;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // power[7:0], spin_angle[17:8], spin_intensity[27:18]
  logic [1:0]  in_tuser;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // wheel_speed_a[8:0], wheel_speed_b[17:9], wheel_speed_c[26:18],
                           // write_a[27], write_b[28], write_c[29]

  wheel_mix_board board = new();

  bit          idle_off = 1'b0;   // set to run both sides without gaps
  int          quiet_cycles = 0;
  logic [7:0]  last_pw = 8'd0;
  logic [9:0]  last_ang = NO_SPIN;
  logic [9:0]  last_inten = 10'd0;

  three_wheel_spin_speed_mixer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Gap length in cycles for one beat, zero while idling is switched off.
  function automatic int idle_len();
    return idle_off ? 0 : $urandom_range(0, 4);
  endfunction

  // Offer one beat after a random gap; hold it until taken, then note it.
  // Valid stays high into the next beat when that one has no gap.
  task automatic drive_beat(input logic [1:0] act, input logic [7:0] pw,
                            input logic [9:0] ang, input logic [9:0] inten);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, inten, ang, pw};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    board.note_beat(act, pw, ang, inten);
    last_pw    = pw;
    last_ang   = ang;
    last_inten = inten;
  endtask

  // Hold the sender off until every outstanding result has drained.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // One random beat: mostly spins within 0..359 at moderate intensity, with
  // wrapped and negative angles, reverse intensities, clears and repeats of
  // the previous command so that unchanged wheels show up.
  task automatic random_beat();
    logic [1:0] act;
    logic [7:0] pw;
    logic [9:0] ang;
    logic [9:0] inten;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) act = ACT_APPLY;
    else if (pick < 80) act = ACT_PREVIEW;
    else if (pick < 90) act = ACT_CLEAR;
    else act = ACT_SPARE;

    if ($urandom_range(0, 99) < 18) begin
      // repeat the last command, sometimes with a fresh random intensity
      pw    = last_pw;
      ang   = last_ang;
      inten = last_inten;
      if ($urandom_range(0, 1) == 0) inten = 10'($urandom_range(0, 1023));
      if (act != ACT_CLEAR) act = ACT_APPLY;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 5) pw = 8'd0;
      else if (pick < 12) pw = 8'd255;
      else pw = 8'($urandom_range(0, 255));

      pick = $urandom_range(0, 99);
      if (pick < 70) ang = 10'($urandom_range(0, 359));
      else if (pick < 80) ang = 10'($urandom_range(360, 511));
      else if (pick < 88) ang = NO_SPIN;
      else ang = 10'($urandom_range(512, 1023));

      pick = $urandom_range(0, 99);
      if (pick < 8) inten = 10'd0;
      else if (pick < 18) inten = 10'd255;
      else if (pick < 68) inten = 10'($urandom_range(1, 254));
      else inten = 10'($urandom_range(256, 1023));
    end
    drive_beat(act, pw, ang, inten);
  endtask

  // Sink: draw a stall per beat, then hold ready until a beat is taken.
  initial begin
    int stall;
    out_tready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = idle_len();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Check every result beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_beat(out_tdata);
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("three_wheel_spin_speed_mixer regression: fail");
      $finish;
    end
  end

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_APPLY;
    rst_n     <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, every action, wrapped and negative angles,
    // zero intensity, reverse clamp and cache hit, miss and clear.
    drive_beat(ACT_APPLY,   8'd0,   NO_SPIN, 10'd0);
    drive_beat(ACT_APPLY,   8'd255, NO_SPIN, 10'd255);
    drive_beat(ACT_APPLY,   8'd255, NO_SPIN, 10'd255);   // cache hit, no writes
    drive_beat(ACT_PREVIEW, 8'd255, 10'd0,   10'd255);
    drive_beat(ACT_APPLY,   8'd255, 10'd0,   10'd255);
    drive_beat(ACT_APPLY,   8'd200, 10'd120, 10'd1023);  // reverse, clamped
    drive_beat(ACT_APPLY,   8'd255, 10'd359, 10'd1023);
    drive_beat(ACT_APPLY,   8'd128, 10'd360, 10'd100);   // wraps to 0
    drive_beat(ACT_APPLY,   8'd128, 10'd511, 10'd300);   // wraps to 151
    drive_beat(ACT_APPLY,   8'd77,  10'd512, 10'd500);   // most negative angle
    drive_beat(ACT_APPLY,   8'd77,  10'd90,  10'd0);     // zero intensity
    drive_beat(ACT_CLEAR,   8'd255, 10'd45,  10'd1023);
    drive_beat(ACT_APPLY,   8'd77,  10'd90,  10'd0);     // all writes after clear
    drive_beat(ACT_SPARE,   8'd10,  10'd45,  10'd255);
    drive_beat(ACT_PREVIEW, 8'd0,   10'd240, 10'd1023);
    drive_beat(ACT_APPLY,   8'd1,   10'd180, 10'd1);     // rounding near a half
    drive_beat(ACT_APPLY,   8'd255, 10'd270, 10'd510);
    drive_beat(ACT_CLEAR,   8'd0,   NO_SPIN, 10'd0);
    drive_beat(ACT_CLEAR,   8'd0,   NO_SPIN, 10'd0);
    drive_beat(ACT_APPLY,   8'd255, 10'd60,  10'd255);
    drive_beat(ACT_APPLY,   8'd255, 10'd60,  10'd255);
    drive_beat(ACT_APPLY,   8'd255, 10'd300, 10'd768);
    drain_results();

    // Random: stretches with no idling every few hundred beats, and one
    // full drain midway.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      idle_off = ((n % 300) >= 240);
      if (n == RANDOM_BEATS / 2) drain_results();
      random_beat();
    end
    idle_off = 1'b0;

    // Drain, then wait for any stray result beat.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (30) @(posedge clk);
    if (board.errors == 0) begin
      $display("three_wheel_spin_speed_mixer regression: pass");
    end else begin
      $display("three_wheel_spin_speed_mixer regression: fail");
    end
    $finish;
  end

endmodule
